// File: rtl/ptpc_pkg.sv
// shared types and constants of the page translate and permission check unit
package ptpc_pkg;

	localparam int ENTRIES   = 64;
	localparam int IDX_W     = $clog2(ENTRIES);
	localparam int VPN_W     = 56;
	localparam int ADDR_W    = 64;
	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 1;

	localparam logic [4:0] SHIFT_MIN   = 5'd8;
	localparam logic [4:0] SHIFT_MAX   = 5'd28;
	localparam logic [4:0] SHIFT_RESET = 5'd12;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PAGE_SHIFT = 1'b0,
		CFG_XLATE_EN   = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		FN_ACCESS = 3'd0,
		FN_MAP    = 3'd1,
		FN_UNMAP  = 3'd2,
		FN_SETP   = 3'd3,
		FN_CLEAR  = 3'd4
	} func_t;

	typedef enum logic [1:0] {
		KIND_READ  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_EXEC  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		STS_OK        = 3'd0,
		STS_UNMAPPED  = 3'd1,
		STS_NO_READ   = 3'd2,
		STS_NO_WRITE  = 3'd3,
		STS_NO_EXEC   = 3'd4,
		STS_SET_UNMAP = 3'd5,
		STS_FULL      = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_RESP
	} state_t;

	typedef struct packed {
		logic [VPN_W-1:0] tag;
		logic [VPN_W-1:0] base;
		logic [2:0]       perms;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: rtl/ptpc_if.sv
// request and response channel interfaces
interface ptpc_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] func;
	logic [63:0] virt_addr;
	logic [63:0] phys_addr;
	logic [2:0] perm_bits;
	logic [1:0] access_kind;

	modport source (output valid, func, virt_addr, phys_addr, perm_bits, access_kind,
		input ready);
	modport sink (input valid, func, virt_addr, phys_addr, perm_bits, access_kind,
		output ready);
endinterface

interface ptpc_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] phys_out;
	logic [2:0]  status;

	modport source (output valid, phys_out, status, input ready);
	modport sink (input valid, phys_out, status, output ready);
endinterface

// File: rtl/ptpc_ram.sv
// generic single write port ram with registered read
module ptpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/page_translate_permission_check_unit.sv
// page table with permission check: slot search over a ram, read-modify-write of the entry
// flow: clear, no-op and pass-through transactions go from acceptance to the response state and
//   then into the output register once it is free; searches run until a hit or the last slot
// one transaction at a time; the next is taken the cycle after the result moves
//   to the output register
// reset: all slot valid bits cleared, page_shift 12, translation enabled, output empty
module page_translate_permission_check_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	ptpc_req_if.sink                            req,
	ptpc_rsp_if.source                          rsp,
	input  logic                                cfg_we,
	input  logic [ptpc_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [ptpc_pkg::CFG_W-1:0]          cfg_wdata
);
	import ptpc_pkg::*;

	localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

	// configuration
	logic [4:0] shift_q;
	logic       xlate_q;
	logic [4:0] eff_sh;

	// control
	state_t state_q, state_d;
	logic   accept;
	logic   needs_scan;

	// latched transaction
	func_t              func_q;
	logic [VPN_W-1:0]   vpn_q;
	logic [VPN_W-1:0]   pbase_q;
	logic [2:0]         perms_q;
	logic [1:0]         kind_q;
	logic [ADDR_W-1:0]  va_q;
	logic [4:0]         sh_q;

	// slot valid bits live in flops so clear empties the table without a scan
	logic [ENTRIES-1:0] valid_q;

	// scan pipeline: address issue, then check of the registered read data
	logic [IDX_W-1:0]   addr_q;
	logic               issue_q;
	logic               chk_vld_s1;
	logic [IDX_W-1:0]   chk_idx_s1;
	logic               free_vld_q;
	logic [IDX_W-1:0]   free_idx_q;

	// ram ports
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	entry_t             ram_wdata;
	entry_t             ram_rdata;

	// finish-of-scan decisions
	logic               hit;
	logic               done;
	logic               free_any;
	logic [IDX_W-1:0]   free_sel;
	logic               clr_vld;
	logic [ADDR_W-1:0]  fin_phys;
	status_t            fin_status;
	logic               perm_ok;
	status_t            perm_fault;

	// result and output registers
	logic [ADDR_W-1:0]  res_phys_q;
	status_t            res_status_q;
	logic               out_load;
	logic               out_vld_q;
	logic [ADDR_W-1:0]  out_phys_q;
	status_t            out_status_q;

	ptpc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(ENTRIES)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(addr_q),
		.rdata(ram_rdata)
	);

	// page shift clamped into the supported range
	always_comb begin
		eff_sh = shift_q;
		if (shift_q < SHIFT_MIN) begin
			eff_sh = SHIFT_MIN;
		end else if (shift_q > SHIFT_MAX) begin
			eff_sh = SHIFT_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= SHIFT_RESET;
			xlate_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_PAGE_SHIFT: shift_q <= cfg_wdata;
				CFG_XLATE_EN:   xlate_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign accept = req.valid && req.ready;

	// map, unmap, set and translated access need a slot search; clear does not
	always_comb begin
		case (req.func)
			FN_ACCESS:                 needs_scan = xlate_q;
			FN_MAP, FN_UNMAP, FN_SETP: needs_scan = 1'b1;
			default:                   needs_scan = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = needs_scan ? S_SCAN : S_RESP;
				end
			end
			S_SCAN: begin
				if (done) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// permission check of the matched entry
	always_comb begin
		case (kind_q)
			KIND_READ: begin
				perm_ok    = ram_rdata.perms[0];
				perm_fault = STS_NO_READ;
			end
			KIND_WRITE: begin
				perm_ok    = ram_rdata.perms[1];
				perm_fault = STS_NO_WRITE;
			end
			KIND_EXEC: begin
				perm_ok    = ram_rdata.perms[2];
				perm_fault = STS_NO_EXEC;
			end
			default: begin
				perm_ok    = 1'b0;
				perm_fault = STS_NO_READ;
			end
		endcase
	end

	// outputs: handshake, scan termination, write-back
	always_comb begin
		req.ready = (state_q == S_IDLE);
		out_load  = (state_q == S_RESP) && (!out_vld_q || rsp.ready);

		// lowest matching slot wins since the scan runs upward and stops on the first hit
		hit  = (state_q == S_SCAN) && chk_vld_s1 && valid_q[chk_idx_s1]
			&& (ram_rdata.tag == vpn_q);
		done = (state_q == S_SCAN) && chk_vld_s1 && (hit || chk_idx_s1 == LAST);

		free_any = free_vld_q || (chk_vld_s1 && !valid_q[chk_idx_s1]);
		free_sel = free_vld_q ? free_idx_q : chk_idx_s1;

		ram_we     = 1'b0;
		ram_waddr  = chk_idx_s1;
		ram_wdata  = ram_rdata;
		clr_vld    = 1'b0;
		fin_phys   = '0;
		fin_status = STS_OK;

		if (done) begin
			case (func_q)
				FN_ACCESS: begin
					if (!hit) begin
						fin_status = STS_UNMAPPED;
					end else if (perm_ok) begin
						// low page bits of the shifted base are zero, so or adds the offset
						fin_phys = (ADDR_W'(ram_rdata.base) << sh_q)
							| (va_q & ((ADDR_W'(1) << sh_q) - ADDR_W'(1)));
					end else begin
						fin_status = perm_fault;
					end
				end
				FN_MAP: begin
					if (hit || free_any) begin
						ram_we          = 1'b1;
						ram_waddr       = hit ? chk_idx_s1 : free_sel;
						ram_wdata.tag   = vpn_q;
						ram_wdata.base  = pbase_q;
						ram_wdata.perms = perms_q;
					end else begin
						fin_status = STS_FULL;
					end
				end
				FN_UNMAP: begin
					clr_vld = hit;
				end
				FN_SETP: begin
					if (hit) begin
						// read-modify-write: tag and base come back from the read
						ram_we          = 1'b1;
						ram_wdata.perms = perms_q;
					end else begin
						fin_status = STS_SET_UNMAP;
					end
				end
				default: ;
			endcase
		end
	end

	// transaction capture and scan pipeline
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= func_t'(req.func);
			vpn_q   <= VPN_W'(req.virt_addr >> eff_sh);
			pbase_q <= VPN_W'(req.phys_addr >> eff_sh);
			perms_q <= req.perm_bits;
			kind_q  <= req.access_kind;
			va_q    <= req.virt_addr;
			sh_q    <= eff_sh;
			// pass-through when translation is off, zero for every other non-search item
			res_phys_q   <= (req.func == FN_ACCESS && !xlate_q) ? req.virt_addr : '0;
			res_status_q <= STS_OK;
		end else if (done) begin
			res_phys_q   <= fin_phys;
			res_status_q <= fin_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q     <= '0;
			issue_q    <= 1'b0;
			chk_vld_s1 <= 1'b0;
			chk_idx_s1 <= '0;
			free_vld_q <= 1'b0;
			free_idx_q <= '0;
		end else if (accept) begin
			addr_q     <= '0;
			issue_q    <= 1'b1;
			chk_vld_s1 <= 1'b0;
			free_vld_q <= 1'b0;
		end else if (state_q == S_SCAN) begin
			chk_vld_s1 <= issue_q;
			chk_idx_s1 <= addr_q;
			if (issue_q) begin
				if (addr_q == LAST) begin
					issue_q <= 1'b0;
				end else begin
					addr_q <= addr_q + 1'b1;
				end
			end
			// remember the first empty slot in case no tag matches
			if (chk_vld_s1 && !free_vld_q && !valid_q[chk_idx_s1]) begin
				free_vld_q <= 1'b1;
				free_idx_q <= chk_idx_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (accept && req.func == FN_CLEAR) begin
			valid_q <= '0;
		end else if (ram_we) begin
			valid_q[ram_waddr] <= 1'b1;
		end else if (clr_vld) begin
			valid_q[chk_idx_s1] <= 1'b0;
		end
	end

	// output register: a finished result may wait while the next transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_phys_q   <= res_phys_q;
			out_status_q <= res_status_q;
		end
	end

	assign rsp.valid    = out_vld_q;
	assign rsp.phys_out = out_phys_q;
	assign rsp.status   = out_status_q;

	// every accepted transaction leads to a scan or straight to the response stage
	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_SCAN || state_q == S_RESP))
		else $error("accepted transaction did not start");

	// a write-back leaves its slot valid
	a_write_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> valid_q[$past(ram_waddr)])
		else $error("written slot not valid");

	// the remembered free slot stays free during the scan
	a_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && free_vld_q) |-> !valid_q[free_idx_q])
		else $error("free slot marked valid");

	// a map or set never writes without a hit or a free slot
	a_write_cause: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (done && (hit || (func_q == FN_MAP && free_any))))
		else $error("unexpected table write");

endmodule

// File: verif/testbench.sv
// self-checking testbench for the page translate and permission check unit
`timescale 1ns / 100ps

module testbench;
	import ptpc_pkg::*;

	// spare function codes and the spare access kind: the unit treats them as no-ops or faults
	localparam logic [2:0] FN_SPARE_LO = 3'd5;
	localparam logic [2:0] FN_SPARE_HI = 3'd7;
	localparam logic [1:0] KIND_SPARE  = 2'd3;

	// permission bit masks
	localparam logic [2:0] PERM_NONE = 3'b000;
	localparam logic [2:0] PERM_R    = 3'b001;
	localparam logic [2:0] PERM_W    = 3'b010;
	localparam logic [2:0] PERM_X    = 3'b100;
	localparam logic [2:0] PERM_ALL  = 3'b111;

	localparam logic [63:0] ALL_ONES = {ADDR_W{1'b1}};

	localparam int POOL_SIZE      = 96;   // more pages than slots, so the table fills up
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 400;

	typedef struct {
		logic [2:0]        func;
		logic [ADDR_W-1:0] virt_addr;
		logic [ADDR_W-1:0] phys_addr;
		logic [2:0]        perm_bits;
		logic [1:0]        access_kind;
	} xlat_req_t;

	typedef struct {
		logic [ADDR_W-1:0] phys;
		status_t           status;
	} xlat_result_t;

	// shadow page table plus the queue of translation results still owed by the unit
	class xlat_scoreboard;
		bit               slot_used[ENTRIES];
		logic [VPN_W-1:0] slot_tag[ENTRIES];
		logic [VPN_W-1:0] slot_base[ENTRIES];
		logic [2:0]       slot_perm[ENTRIES];
		logic [CFG_W-1:0] shift_reg;
		bit               xlate_on;
		xlat_result_t     expected_xlat[$];
		int               errors;

		function new();
			shift_reg = SHIFT_RESET;
			xlate_on  = 1'b1;
			errors    = 0;
			foreach (slot_used[i]) slot_used[i] = 1'b0;
		endfunction

		function void set_register(cfg_idx_t idx, logic [CFG_W-1:0] value);
			if (idx == CFG_PAGE_SHIFT) shift_reg = value;
			else xlate_on = value[0];
		endfunction

		function int unsigned page_shift_eff();
			if (shift_reg < SHIFT_MIN) return int'(SHIFT_MIN);
			if (shift_reg > SHIFT_MAX) return int'(SHIFT_MAX);
			return int'(shift_reg);
		endfunction

		function int pending();
			return expected_xlat.size();
		endfunction

		// lowest valid slot holding this page number
		function int find_page(logic [ADDR_W-1:0] vpn);
			for (int i = 0; i < ENTRIES; i++)
				if (slot_used[i] && {{(ADDR_W-VPN_W){1'b0}}, slot_tag[i]} == vpn) return i;
			return -1;
		endfunction

		function int find_free();
			for (int i = 0; i < ENTRIES; i++)
				if (!slot_used[i]) return i;
			return -1;
		endfunction

		function void note_request(xlat_req_t r);
			int unsigned       sh;
			int                s;
			logic [ADDR_W-1:0] vpn;
			logic [ADDR_W-1:0] offs;
			logic [ADDR_W-1:0] ppn;
			bit                ok;
			status_t           deny;
			xlat_result_t      e;
			sh = page_shift_eff();
			vpn = r.virt_addr >> sh;
			offs = r.virt_addr & ((64'd1 << sh) - 64'd1);
			ppn = r.phys_addr >> sh;
			e.phys = '0;
			e.status = STS_OK;
			case (r.func)
			FN_ACCESS: begin
				if (!xlate_on) begin
					e.phys = r.virt_addr;
				end else begin
					s = find_page(vpn);
					if (s < 0) begin
						e.status = STS_UNMAPPED;
					end else begin
						case (r.access_kind)
						KIND_READ: begin
							ok = (slot_perm[s] & PERM_R) != PERM_NONE;
							deny = STS_NO_READ;
						end
						KIND_WRITE: begin
							ok = (slot_perm[s] & PERM_W) != PERM_NONE;
							deny = STS_NO_WRITE;
						end
						KIND_EXEC: begin
							ok = (slot_perm[s] & PERM_X) != PERM_NONE;
							deny = STS_NO_EXEC;
						end
						default: begin
							ok = 1'b0;
							deny = STS_NO_READ;
						end
						endcase
						if (ok) e.phys = ({{(ADDR_W-VPN_W){1'b0}}, slot_base[s]} << sh) + offs;
						else e.status = deny;
					end
				end
			end
			FN_MAP: begin
				s = find_page(vpn);
				if (s < 0) s = find_free();
				if (s < 0) begin
					e.status = STS_FULL;
				end else begin
					slot_used[s] = 1'b1;
					slot_tag[s]  = vpn[VPN_W-1:0];
					slot_base[s] = ppn[VPN_W-1:0];
					slot_perm[s] = r.perm_bits;
				end
			end
			FN_UNMAP: begin
				s = find_page(vpn);
				if (s >= 0) slot_used[s] = 1'b0;
			end
			FN_SETP: begin
				s = find_page(vpn);
				if (s < 0) e.status = STS_SET_UNMAP;
				else slot_perm[s] = r.perm_bits;
			end
			FN_CLEAR: begin
				foreach (slot_used[i]) slot_used[i] = 1'b0;
			end
			default: ;
			endcase
			expected_xlat.insert(expected_xlat.size(), e);
		endfunction

		function void flag(string what, logic [ADDR_W-1:0] exp_v, logic [ADDR_W-1:0] act_v);
			errors++;
			$display("%0t: %s mismatch: expected %h, actual %h", $time, what, exp_v, act_v);
		endfunction

		function void check_response(logic [ADDR_W-1:0] phys, logic [2:0] status);
			xlat_result_t e;
			if (expected_xlat.size() == 0) begin
				errors++;
				$display("%0t: unexpected response: expected none, actual phys_out %h status %0d",
					$time, phys, status);
				return;
			end
			e = expected_xlat.pop_front();
			if (phys !== e.phys) flag("phys_out", e.phys, phys);
			if (status !== e.status) flag("status", 64'(e.status), 64'(status));
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_wdata;

	ptpc_req_if req_ch();
	ptpc_rsp_if rsp_ch();

	page_translate_permission_check_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	xlat_scoreboard xlat_sb = new();

	// page numbers that random traffic keeps hitting, so maps, lookups and unmaps meet
	logic [ADDR_W-1:0] page_pool[POOL_SIZE];

	// idling knobs, percent per cycle; hold request is picked up by the receiver process
	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;
	int rx_hold_len  = 0;
	int idle_cycles  = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// response side: random stalls, plus one long hold-off counted here
	initial begin
		int n;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_len > 0) begin
				n = rx_hold_len;
				rx_hold_len = 0;
				rsp_ch.ready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// every accepted response is checked against the oldest expected translation
	always @(posedge clk) begin
		if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
			xlat_sb.check_response(rsp_ch.phys_out, rsp_ch.status);
	end

	// watchdog: too long without any transaction on either channel ends the run
	always @(posedge clk) begin
		if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
			(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL page_translate_permission_check_unit");
				$finish;
			end
		end
	end

	// called just after a falling edge; returns just after the falling edge that follows acceptance
	task automatic send_request(input xlat_req_t r);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.func        <= r.func;
		req_ch.virt_addr   <= r.virt_addr;
		req_ch.phys_addr   <= r.phys_addr;
		req_ch.perm_bits   <= r.perm_bits;
		req_ch.access_kind <= r.access_kind;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		xlat_sb.note_request(r);
		@(negedge clk);
	endtask

	task automatic send_fields(input logic [2:0] fn, input logic [ADDR_W-1:0] va,
		input logic [ADDR_W-1:0] pa, input logic [2:0] perms, input logic [1:0] kind);
		xlat_req_t r;
		r.func        = fn;
		r.virt_addr   = va;
		r.phys_addr   = pa;
		r.perm_bits   = perms;
		r.access_kind = kind;
		send_request(r);
	endtask

	// stop offering, wait for every owed response, then let the unit settle
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (xlat_sb.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// a wait after each write so the enable never gets two updates in one step
	task automatic write_cfg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		xlat_sb.set_register(idx, value);
		@(negedge clk);
	endtask

	// mostly pool pages with a random offset at the current page size, some raw addresses
	function automatic xlat_req_t random_request();
		xlat_req_t         r;
		int unsigned       pick;
		int unsigned       sh;
		logic [ADDR_W-1:0] mask;
		sh = xlat_sb.page_shift_eff();
		mask = (64'd1 << sh) - 64'd1;
		pick = $urandom_range(999);
		if (pick < 450) r.func = FN_ACCESS;
		else if (pick < 720) r.func = FN_MAP;
		else if (pick < 800) r.func = FN_UNMAP;
		else if (pick < 930) r.func = FN_SETP;
		else if (pick < 940) r.func = FN_CLEAR;
		else r.func = 3'($urandom_range(int'(FN_SPARE_HI), int'(FN_SPARE_LO)));
		if ($urandom_range(9) == 0)
			r.virt_addr = {$urandom, $urandom};
		else
			r.virt_addr = (page_pool[$urandom_range(POOL_SIZE-1)] << sh) |
				({$urandom, $urandom} & mask);
		r.phys_addr = {$urandom, $urandom};
		r.perm_bits = 3'($urandom_range(7));
		if ($urandom_range(9) == 0) r.access_kind = KIND_SPARE;
		else r.access_kind = 2'($urandom_range(int'(KIND_EXEC)));
		return r;
	endfunction

	task automatic start_phase(input logic [CFG_W-1:0] shift_val, input logic [CFG_W-1:0] en_val);
		drain();
		write_cfg(CFG_PAGE_SHIFT, shift_val);
		write_cfg(CFG_XLATE_EN, en_val);
	endtask

	// hold_at: item at which the receiver starts a long hold-off
	// pause_at: item before which the sender waits for all responses
	task automatic run_phase(input int n_items, input int tx_pct, input int rx_pct,
		input int hold_at, input int pause_at);
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		for (int i = 0; i < n_items; i++) begin
			if (i == hold_at) rx_hold_len = HOLD_CYCLES;
			if (i == pause_at) drain();
			send_request(random_request());
		end
	endtask

	// directed corner cases at the reset page size of 4 KiB
	task automatic directed_checks();
		send_fields(FN_ACCESS, 64'h0, 64'h0, PERM_NONE, KIND_READ);          // empty table
		send_fields(FN_MAP, 64'h0, ALL_ONES, PERM_ALL, KIND_READ);
		send_fields(FN_ACCESS, 64'hfff, 64'h0, PERM_NONE, KIND_EXEC);        // top offset, all-ones base
		send_fields(FN_MAP, ALL_ONES, 64'h0, PERM_NONE, KIND_READ);          // top page, no rights
		send_fields(FN_ACCESS, ALL_ONES, 64'h0, PERM_NONE, KIND_READ);
		send_fields(FN_ACCESS, ALL_ONES, 64'h0, PERM_NONE, KIND_WRITE);
		send_fields(FN_ACCESS, ALL_ONES, 64'h0, PERM_NONE, KIND_EXEC);
		send_fields(FN_ACCESS, ALL_ONES, 64'h0, PERM_NONE, KIND_SPARE);
		send_fields(FN_SETP, ALL_ONES, 64'h0, PERM_ALL, KIND_READ);
		send_fields(FN_ACCESS, ALL_ONES, 64'h0, PERM_NONE, KIND_SPARE);      // spare kind faults anyway
		send_fields(FN_ACCESS, ALL_ONES, 64'h0, PERM_NONE, KIND_WRITE);
		send_fields(FN_SETP, 64'h5000, 64'h0, PERM_ALL, KIND_READ);          // set on a missing page
		send_fields(FN_UNMAP, 64'h5000, 64'h0, PERM_NONE, KIND_READ);        // unmap of a missing page
		send_fields(FN_UNMAP, ALL_ONES, 64'h0, PERM_NONE, KIND_READ);
		send_fields(FN_ACCESS, ALL_ONES, 64'h0, PERM_NONE, KIND_READ);
		for (int f = FN_SPARE_LO; f <= FN_SPARE_HI; f++)
			send_fields(3'(f), {$urandom, $urandom}, {$urandom, $urandom}, PERM_ALL, KIND_EXEC);
		send_fields(FN_MAP, 64'h1000, 64'h8000_0000_0000_0000, PERM_R, KIND_READ);
		send_fields(FN_ACCESS, 64'h1234, 64'h0, PERM_NONE, KIND_WRITE);
		send_fields(FN_ACCESS, 64'h1abc, 64'h0, PERM_NONE, KIND_READ);
		send_fields(FN_SETP, 64'h1000, 64'h0, PERM_W | PERM_X, KIND_READ);
		send_fields(FN_ACCESS, 64'h1abc, 64'h0, PERM_NONE, KIND_READ);
		send_fields(FN_CLEAR, 64'h0, 64'h0, PERM_NONE, KIND_READ);
		send_fields(FN_ACCESS, 64'h0, 64'h0, PERM_NONE, KIND_READ);
	endtask

	initial begin
		// known values on every input from time zero
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_idx            = CFG_PAGE_SHIFT;
		cfg_wdata          = '0;
		req_ch.valid       = 1'b0;
		req_ch.func        = FN_ACCESS;
		req_ch.virt_addr   = '0;
		req_ch.phys_addr   = '0;
		req_ch.perm_bits   = PERM_NONE;
		req_ch.access_kind = KIND_READ;

		// edge pages plus random ones
		page_pool[0] = '0;
		page_pool[1] = ALL_ONES;
		page_pool[2] = 64'd1;
		for (int i = 3; i < POOL_SIZE; i++) page_pool[i] = {$urandom, $urandom};

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		directed_checks();

		// page size sweep including values outside the legal range;
		// the table is kept across changes so old page numbers meet new ones
		start_phase(5'd12, 5'd1);
		run_phase(200, 0, 0, -1, -1);
		start_phase(5'd0, 5'd1);
		run_phase(200, 72, 0, -1, -1);
		start_phase(5'd31, 5'd1);
		run_phase(200, 0, 72, -1, -1);
		// translation off: pass-through, upper enable-data bits ignored
		start_phase(5'd7, 5'b11110);
		run_phase(150, 13, 13, -1, -1);
		// long receiver hold-off while requests keep coming
		start_phase(5'd29, 5'd1);
		run_phase(150, 0, 0, 20, -1);
		// sender pause until every response is in
		start_phase(5'd8, 5'd1);
		run_phase(200, 13, 13, -1, 100);
		start_phase(5'd28, 5'b00001);
		run_phase(100, 0, 0, -1, -1);
		start_phase(5'd20, 5'd1);
		run_phase(100, 0, 72, -1, -1);

		drain();
		repeat (20) @(negedge clk);
		if (xlat_sb.errors == 0 && xlat_sb.pending() == 0) begin
			$display("PASS page_translate_permission_check_unit");
		end else begin
			$display("FAIL page_translate_permission_check_unit");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/ptpc_pkg.sv
rtl/ptpc_if.sv
rtl/ptpc_ram.sv
rtl/page_translate_permission_check_unit.sv
verif/testbench.sv
